// ===== src/mmzs_pkg.sv =====
// Shared types and constants for the memory map zone splitter.
`timescale 1ns / 1ps

package mmzs_pkg;

    // Addresses below 4 GiB need 32 bits; a clipped end of exactly 4 GiB needs 33.
    localparam int ADDR_W = 32;
    localparam int END_W  = ADDR_W + 1;

    localparam logic [END_W-1:0] BOUND_RESERVED = 33'h0_0010_0000;
    localparam logic [END_W-1:0] BOUND_DMA      = 33'h0_0100_0000;
    localparam logic [END_W-1:0] BOUND_KERNEL   = 33'h0_3800_0000;
    localparam logic [END_W-1:0] BOUND_HIGH     = 33'h1_0000_0000;

    localparam logic [7:0] RAM_TYPE_USABLE = 8'd1;

    localparam logic [1:0] KIND_RESV    = 2'd0;
    localparam logic [1:0] KIND_DMA     = 2'd1;
    localparam logic [1:0] KIND_NORMAL  = 2'd2;
    localparam logic [1:0] KIND_HIGHMEM = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch a new entry request
        logic advance;  // current piece was taken, step to the next one
    } mmzs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic keep;     // entry on the input is usable RAM below 4 GiB
        logic last;     // current piece is the final one of its entry
    } mmzs_sts_t;

endpackage

// ===== src/mmzs_ctrl.sv =====
// Controller state machine for the memory map zone splitter.
`timescale 1ns / 1ps

module mmzs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  mmzs_pkg::mmzs_sts_t sts,
    output mmzs_pkg::mmzs_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_EMIT);
    assign cmd.load    = s_valid && s_ready;
    assign cmd.advance = m_valid && m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // Dropped entries are taken and leave no piece behind.
                if (cmd.load && sts.keep) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cmd.advance && sts.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/mmzs_dpath.sv =====
// Datapath for the memory map zone splitter: entry registers, boundary walk, slot counter.
`timescale 1ns / 1ps

module mmzs_dpath #(
    parameter int MAX_ZONES = 32,
    parameter int PAGE_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mmzs_pkg::mmzs_cmd_t cmd,
    output mmzs_pkg::mmzs_sts_t sts,
    input  logic [63:0]         region_start,
    input  logic [63:0]         region_length,
    input  logic [7:0]          region_type,
    input  logic                map_first,
    output logic [1:0]          zone_kind,
    output logic [19:0]         first_page,
    output logic [20:0]         page_count,
    output logic [4:0]          zone_slot,
    output logic                table_full,
    output logic                last_piece
);

    localparam int SLOT_W = $clog2(MAX_ZONES + 1);
    localparam int ADDR_W = mmzs_pkg::ADDR_W;
    localparam int END_W  = mmzs_pkg::END_W;

    logic [ADDR_W-1:0] start_reg;
    logic [END_W-1:0]  end_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [END_W-1:0]  in_sum;
    logic              in_clip;
    logic [END_W-1:0]  in_end;
    logic [END_W-1:0]  bound;
    logic [END_W-1:0]  piece_end;
    logic [END_W-1:0]  piece_len;
    logic              full;

    // Entry end, clipped at 4 GiB; a nonzero upper length word always clips.
    assign in_sum   = {1'b0, region_start[ADDR_W-1:0]} + {1'b0, region_length[ADDR_W-1:0]};
    assign in_clip  = (region_length[63:ADDR_W] != '0) || in_sum[END_W-1];
    assign in_end   = in_clip ? mmzs_pkg::BOUND_HIGH : in_sum;
    assign sts.keep = (region_start[63:ADDR_W] == '0)
                   && (region_type == mmzs_pkg::RAM_TYPE_USABLE);

    always_comb begin
        priority if ({1'b0, start_reg} < mmzs_pkg::BOUND_RESERVED) begin
            zone_kind = mmzs_pkg::KIND_RESV;
            bound     = mmzs_pkg::BOUND_RESERVED;
        end else if ({1'b0, start_reg} < mmzs_pkg::BOUND_DMA) begin
            zone_kind = mmzs_pkg::KIND_DMA;
            bound     = mmzs_pkg::BOUND_DMA;
        end else if ({1'b0, start_reg} < mmzs_pkg::BOUND_KERNEL) begin
            zone_kind = mmzs_pkg::KIND_NORMAL;
            bound     = mmzs_pkg::BOUND_KERNEL;
        end else begin
            zone_kind = mmzs_pkg::KIND_HIGHMEM;
            bound     = mmzs_pkg::BOUND_HIGH;
        end
    end

    // The high zone reaches to the clip point, so its piece always ends the entry.
    assign sts.last   = (end_reg <= bound);
    assign last_piece = sts.last;
    assign piece_end  = sts.last ? end_reg : bound;
    assign piece_len  = piece_end - {1'b0, start_reg};
    assign first_page = 20'(start_reg >> PAGE_BITS);
    assign page_count = 21'(piece_len >> PAGE_BITS);

    assign full       = (slot_reg >= SLOT_W'(MAX_ZONES));
    assign table_full = full;
    assign zone_slot  = full ? 5'd0 : 5'(slot_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            start_reg <= region_start[ADDR_W-1:0];
            end_reg   <= in_end;
        end else if (cmd.advance) begin
            start_reg <= bound[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (cmd.load && map_first) begin
            slot_reg <= '0;
        end else if (cmd.advance && !full) begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end
    end

    // The counter saturates at the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(MAX_ZONES))
        else $error("slot counter ran past the table size");

    // A piece never starts at or past the clipped end unless it is empty and final.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance && !sts.last |=> ({1'b0, start_reg} < end_reg))
        else $error("boundary walk stepped past the entry end");

endmodule

// ===== src/memory_map_zone_splitter.sv =====
// Top level of the memory map zone splitter.
`timescale 1ns / 1ps
//
// Input channel (s_): one firmware memory-map request per handshake: start,
// length, type and a flag that marks the first entry of a new map, which
// clears the slot counter. Output channel (m_): one zone record per piece.
// An entry that starts at or above 4 GiB, or whose type is not usable RAM,
// is taken and yields nothing. A usable entry is clipped at
// 4 GiB and cut at 1 MiB, 16 MiB and 896 MiB into 1 to 4 pieces.
// The first record is valid the cycle after the request is taken.
// One piece leaves per cycle while the receiver takes them; the entry is walked piece
// by piece through one shared boundary compare and subtract, and the next
// request is taken only after the last piece has left.
// A stalled receiver holds the current record steady; s_ready stays low.
// Reset (aresetn, synchronous, active low) empties the block and clears the
// slot counter. Slots run from 0 to MAX_ZONES-1; later records carry table_full and slot 0.
//
module memory_map_zone_splitter #(
    parameter int MAX_ZONES = 32,
    parameter int PAGE_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_region_start,
    input  logic [63:0] s_region_length,
    input  logic [7:0]  s_region_type,
    input  logic        s_map_first,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_zone_kind,
    output logic [19:0] m_first_page,
    output logic [20:0] m_page_count,
    output logic [4:0]  m_zone_slot,
    output logic        m_table_full,
    output logic        m_last_piece
);

    mmzs_pkg::mmzs_cmd_t cmd;
    mmzs_pkg::mmzs_sts_t sts;

    mmzs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mmzs_dpath #(
        .MAX_ZONES (MAX_ZONES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .region_start  (s_region_start),
        .region_length (s_region_length),
        .region_type   (s_region_type),
        .map_first     (s_map_first),
        .zone_kind     (m_zone_kind),
        .first_page    (m_first_page),
        .page_count    (m_page_count),
        .zone_slot     (m_zone_slot),
        .table_full    (m_table_full),
        .last_piece    (m_last_piece)
    );

    // Only one request is in the block at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while records were pending");

    // A piece that is not the last one is followed by another record.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_piece |=> m_valid)
        else $error("entry ended before its last piece");

    // After the last piece the block is ready for the next request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_piece |=> s_ready && !m_valid)
        else $error("block did not return to idle after the last piece");

    // A piece never holds more than 4 GiB worth of pages.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_page_count <= 21'h10_0000))
        else $error("page count exceeds the 4 GiB span");

endmodule
